>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the base-36 encoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/b36enc_pkg.sv
// ----------------------------------------------------------------------------
// b36enc_pkg
// Shared constants, command/status types and helpers of the base-36 encoder.
// ----------------------------------------------------------------------------
package b36enc_pkg;

    localparam int VALUE_BYTES = 32;
    localparam int MAX_DIGITS  = 50;

    localparam int POS_W   = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
    localparam int DCNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int DADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;
    localparam int ACC_W   = DIGIT_W + BYTE_W;

    // q = (acc * DIV36_MUL) >> DIV36_SHIFT is exact for acc < 32768
    localparam int DIV36_MUL   = 29128;
    localparam int DIV36_SHIFT = 20;
    localparam int PROD_W      = 29;

    localparam logic [DIGIT_W-1:0] DEC_DIGITS       = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO        = 7'd48;  // '0'
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA_BASE  = 7'd87;  // 'a' - 10

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic load;        // shift a new byte into the value store
        logic begin_conv;  // final byte taken: restart digit count
        logic div_step;    // one byte of the long division
        logic rd_en;       // read the next digit from the digit store
        logic send;        // present the digit read last cycle
    } t_cmd;

    typedef struct packed {
        logic pass_last;   // current division step ends a pass
        logic more;        // quotient of this pass is nonzero
        logic last_out;    // digit being sent is the final one
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0]  quot;
        logic [DIGIT_W-1:0] rem;
    } t_div36;

    function automatic t_div36 div36(input logic [ACC_W-1:0] acc);
        logic [PROD_W-1:0] prod;
        logic [ACC_W-1:0]  q36;
        t_div36            res;
        prod     = PROD_W'(acc) * PROD_W'(DIV36_MUL);
        res.quot = prod[DIV36_SHIFT +: BYTE_W];
        q36      = ACC_W'({res.quot, 5'b0}) + ACC_W'({res.quot, 2'b0});
        res.rem  = DIGIT_W'(acc - q36);
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DEC_DIGITS) begin
            ch = CHAR_ZERO + CHAR_W'(d);
        end else begin
            ch = CHAR_ALPHA_BASE + CHAR_W'(d);
        end
        return ch;
    endfunction

endpackage

>>> hdl/b36enc_ram.sv
// ----------------------------------------------------------------------------
// b36enc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module b36enc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/b36enc_ctrl.sv
// ----------------------------------------------------------------------------
// b36enc_ctrl
// Sequencer: byte loading, division passes and digit read-out.
// ----------------------------------------------------------------------------
module b36enc_ctrl import b36enc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_last_byte,
    input  t_status i_status,
    output logic    o_busy,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = !i_rst_n;
                if (i_start && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    if (i_last_byte) begin
                        o_cmd.begin_conv = 1'b1;
                        n_state          = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.pass_last && !i_status.more) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_SEND;
            end
            ST_SEND: begin
                o_cmd.send = 1'b1;
                n_state    = i_status.last_out ? ST_IDLE : ST_READ;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/b36enc_dpath.sv
// ----------------------------------------------------------------------------
// b36enc_dpath
// Value shift store, byte-serial divide-by-36 unit and digit store.
// ----------------------------------------------------------------------------
module b36enc_dpath import b36enc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [BYTE_W-1:0]  i_value_byte,
    output t_status            o_status,
    output logic               o_digit_valid,
    output logic [CHAR_W-1:0]  o_digit_char,
    output logic               o_last_digit
);

    // bytes enter at the low-order end and move toward index 0 (most
    // significant); unfilled leading entries stay zero and do not change
    // the quotient or remainder
    logic [BYTE_W-1:0]  r_val [VALUE_BYTES];
    logic [DIGIT_W-1:0] r_rem;
    logic               r_nz;
    logic [POS_W-1:0]   r_pos;
    logic [DCNT_W-1:0]  r_dcnt;

    t_div36             n_div;
    logic               pass_last;
    logic               dig_we;
    logic [DCNT_W-1:0]  rd_idx;
    logic [DIGIT_W-1:0] rd_digit;

    assign n_div     = div36({r_rem, r_val[0]});
    assign pass_last = (r_pos == POS_W'(VALUE_BYTES - 1));
    assign dig_we    = i_cmd.div_step && pass_last && (r_dcnt < DCNT_W'(MAX_DIGITS));
    assign rd_idx    = r_dcnt - DCNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VALUE_BYTES; i++) begin
                r_val[i] <= '0;
            end
            r_rem  <= '0;
            r_nz   <= 1'b0;
            r_pos  <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.load || i_cmd.div_step) begin
                for (int i = 0; i < VALUE_BYTES - 1; i++) begin
                    r_val[i] <= r_val[i+1];
                end
                r_val[VALUE_BYTES-1] <= i_cmd.load ? i_value_byte : n_div.quot;
            end
            if (i_cmd.begin_conv) begin
                r_rem  <= '0;
                r_nz   <= 1'b0;
                r_pos  <= '0;
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                if (pass_last) begin
                    r_rem <= '0;
                    r_nz  <= 1'b0;
                    r_pos <= '0;
                    if (dig_we) begin
                        r_dcnt <= r_dcnt + DCNT_W'(1);
                    end
                end else begin
                    r_rem <= n_div.rem;
                    r_nz  <= r_nz | (n_div.quot != '0);
                    r_pos <= r_pos + POS_W'(1);
                end
            end else if (i_cmd.send) begin
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end
        end
    end

    // digits are written least significant first, read back in reverse
    b36enc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_ram (
        .i_clk   (i_clk),
        .i_we    (dig_we),
        .i_waddr (r_dcnt[DADDR_W-1:0]),
        .i_wdata (n_div.rem),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_idx[DADDR_W-1:0]),
        .o_rdata (rd_digit)
    );

    assign o_status.pass_last = pass_last;
    assign o_status.more      = r_nz | (n_div.quot != '0);
    assign o_status.last_out  = (r_dcnt == DCNT_W'(1));

    assign o_digit_valid = i_cmd.send;
    assign o_digit_char  = digit_char(rd_digit);
    assign o_last_digit  = i_cmd.send && (r_dcnt == DCNT_W'(1));

endmodule

>>> hdl/base36_encoder_unit.sv
// Operation: a non-final byte is shifted in and the unit stays idle, ready for the
//   next byte; after the final byte, conversion runs one division pass per digit
//   (up to 50 digits) in the byte-serial divide-by-36 unit, each pass stepping
//   through every value byte, then each digit is a RAM read and a beat; busy is high throughout.
// Results are one-cycle strobes; the receiver cannot stall.
// Reset: synchronous active low, clears the value store, counters and sequencer.
// ----------------------------------------------------------------------------
// base36_encoder_unit
// Big-endian byte stream to lower-case base-36 ASCII text, MSD first.
// ----------------------------------------------------------------------------
module base36_encoder_unit import b36enc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [BYTE_W-1:0] i_value_byte,
    input  logic              i_last_byte,
    output logic              o_digit_valid,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic              o_last_digit
);

    t_cmd    cmd;
    t_status status;

    b36enc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last_byte (i_last_byte),
        .i_status    (status),
        .o_busy      (busy),
        .o_cmd       (cmd)
    );

    b36enc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_value_byte  (i_value_byte),
        .o_status      (status),
        .o_digit_valid (o_digit_valid),
        .o_digit_char  (o_digit_char),
        .o_last_digit  (o_last_digit)
    );

endmodule

>>> hdl/b36enc_checker.sv
// ----------------------------------------------------------------------------
// b36enc_checker
// Port-level checks of the base-36 encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b36enc_checker import b36enc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              i_last_byte,
    input logic              o_digit_valid,
    input logic [CHAR_W-1:0] o_digit_char,
    input logic              o_last_digit
);

    logic take_last;
    logic char_ok;

    assign take_last = start && !busy && i_last_byte;
    assign char_ok   = ((o_digit_char >= 7'd48) && (o_digit_char <= 7'd57)) ||
                       ((o_digit_char >= 7'd97) && (o_digit_char <= 7'd122));

    `ASSERT_IMPLY(a_char_range, i_clk, i_rst_n, o_digit_valid, char_ok)
    `ASSERT_IMPLY(a_beat_while_busy, i_clk, i_rst_n, o_digit_valid, busy)
    `ASSERT_NEXT(a_busy_after_last_byte, i_clk, i_rst_n, take_last, busy)
    `ASSERT_NEXT(a_idle_after_text, i_clk, i_rst_n, o_digit_valid && o_last_digit, !busy)
    `ASSERT_NEXT(a_beats_spaced, i_clk, i_rst_n, o_digit_valid, !o_digit_valid)

endmodule

bind base36_encoder_unit b36enc_checker u_b36enc_checker (.*);

>>> tb/sv/tb_base36_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base36_encoder_unit
// Self-checking bench for the byte-stream to base-36 text encoder. Numbers are
// sent byte by byte through the start/busy command port. A local model builds
// each number and converts it to text, and the digit strobes are compared
// against that text in order.
// ----------------------------------------------------------------------------
module tb_base36_encoder_unit;
    import b36enc_pkg::*;

    localparam int NUM_W       = VALUE_BYTES * BYTE_W;
    localparam int ITEM_TARGET = 300;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = VALUE_BYTES * MAX_DIGITS + 4 * MAX_DIGITS;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              is_last;
        int unsigned       gap;
        logic              drain;  // hold off until all text is out
    } t_byte_beat;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } t_digit_beat;

    typedef enum int {
        NUM_ALL_ONES,
        NUM_OVERFLOW,
        NUM_ZEROS,
        NUM_SHORT,
        NUM_LONG,
        NUM_LEAD_ZERO
    } t_num_kind;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic [BYTE_W-1:0] i_value_byte = '0;
    logic              i_last_byte = 1'b0;
    logic              busy;
    logic              o_digit_valid;
    logic [CHAR_W-1:0] o_digit_char;
    logic              o_last_digit;

    t_byte_beat  pending_beats[$];
    t_digit_beat digits_due[$];
    logic [NUM_W-1:0] number_acc = '0;
    t_byte_beat  cur_beat;
    logic        have_beat = 1'b0;
    int unsigned wait_left = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned items_queued = 0;
    string       alphabet = "0123456789abcdefghijklmnopqrstuvwxyz";

    base36_encoder_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value_byte (i_value_byte),
        .i_last_byte  (i_last_byte),
        .o_digit_valid(o_digit_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shift the byte into the number; on the final byte produce its text.
    function automatic void take_byte(input t_byte_beat b);
        logic [DIGIT_W-1:0] rems[$];
        logic [NUM_W-1:0]   quot;
        t_digit_beat        d;
        number_acc = {number_acc[NUM_W-BYTE_W-1:0], b.value};
        if (b.is_last) begin
            quot = number_acc;
            do begin
                // only the least significant digits survive an overflow
                if (rems.size() < MAX_DIGITS)
                    rems.insert(rems.size(), DIGIT_W'(quot % 36));
                quot = quot / 36;
            end while (quot != 0);
            for (int k = rems.size() - 1; k >= 0; k--) begin
                d.ch      = CHAR_W'(alphabet[rems[k]]);
                d.is_last = (k == 0);
                digits_due.insert(digits_due.size(), d);
            end
            number_acc = '0;
        end
    endfunction

    function automatic void queue_byte(input logic [BYTE_W-1:0] v, input logic fin,
                                       input logic burst, input logic drain);
        t_byte_beat b;
        b.value   = v;
        b.is_last = fin;
        b.gap     = burst ? 0 : $urandom_range(0, 8);
        b.drain   = drain;
        pending_beats.insert(pending_beats.size(), b);
        items_queued++;
    endfunction

    function automatic void queue_number(input logic [BYTE_W-1:0] bytes[$],
                                         input logic burst, input logic drain);
        for (int i = 0; i < bytes.size(); i++)
            queue_byte(bytes[i], i == bytes.size() - 1, burst, drain && i == 0);
    endfunction

    function automatic void queue_random_number(input t_num_kind kind);
        logic [BYTE_W-1:0] bytes[$];
        int unsigned       len;
        case (kind)
            NUM_ALL_ONES: begin
                for (int i = 0; i < VALUE_BYTES; i++) bytes.insert(bytes.size(), 8'hFF);
            end
            NUM_OVERFLOW: begin
                len = $urandom_range(VALUE_BYTES + 1, VALUE_BYTES + 8);
                for (int i = 0; i < len; i++)
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            end
            NUM_ZEROS: begin
                len = $urandom_range(1, VALUE_BYTES);
                for (int i = 0; i < len; i++) bytes.insert(bytes.size(), 8'h00);
            end
            NUM_SHORT: begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            end
            NUM_LONG: begin
                len = $urandom_range(1, VALUE_BYTES);
                for (int i = 0; i < len; i++)
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            end
            default: begin
                len = $urandom_range(2, 12);
                for (int i = 0; i < len; i++)
                    bytes.insert(bytes.size(),
                                 i < len / 2 ? 8'h00 : 8'($urandom_range(0, 255)));
            end
        endcase
        queue_number(bytes, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
    endfunction

    // Command driver: one beat per accepted start, optional gap before each.
    always @(posedge i_clk) begin : drive_p
        logic go;
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_value_byte <= '0;
            i_last_byte  <= 1'b0;
        end else begin
            if (start && !busy) begin
                take_byte(cur_beat);
                have_beat = 1'b0;
            end
            go = start && busy;
            if (!go) begin
                if (!have_beat && pending_beats.size() != 0) begin
                    cur_beat  = pending_beats.pop_front();
                    have_beat = 1'b1;
                    wait_left = cur_beat.gap;
                end
                if (have_beat && wait_left != 0)
                    wait_left--;
                else if (have_beat && !(cur_beat.drain && digits_due.size() != 0))
                    go = 1'b1;
            end
            start        <= go;
            i_value_byte <= cur_beat.value;
            i_last_byte  <= cur_beat.is_last;
        end
    end

    // Digit monitor: every strobe must match the oldest predicted digit.
    always @(posedge i_clk) begin : watch_p
        t_digit_beat d;
        if (i_rst_n && o_digit_valid) begin
            if (digits_due.size() == 0) begin
                $display("%0t: unexpected digit char=%h last=%b", $time,
                         o_digit_char, o_last_digit);
                error_count++;
            end else begin
                d = digits_due.pop_front();
                if (o_digit_char !== d.ch) begin
                    $display("%0t: digit_char expected %h actual %h", $time,
                             d.ch, o_digit_char);
                    error_count++;
                end
                if (o_last_digit !== d.is_last) begin
                    $display("%0t: last_digit expected %b actual %b", $time,
                             d.is_last, o_last_digit);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stim_p
        int unsigned n;
        // directed: zero, byte extremes, digit rollover, leading zero bytes
        queue_number('{8'h00}, 1'b0, 1'b0);
        queue_number('{8'hFF}, 1'b0, 1'b0);
        queue_number('{8'd35}, 1'b0, 1'b1);
        queue_number('{8'd36}, 1'b1, 1'b0);
        queue_number('{8'h00, 8'h00}, 1'b0, 1'b0);
        queue_number('{8'h80, 8'h01}, 1'b1, 1'b0);
        queue_number('{8'h00, 8'h7F}, 1'b0, 1'b1);
        queue_number('{8'h01, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0);
        queue_number('{8'h55, 8'hAA}, 1'b1, 1'b0);
        n = 0;
        while (items_queued < ITEM_TARGET) begin
            // width extremes first, then a mix leaning on short numbers
            if (n < 3)
                queue_random_number(t_num_kind'(n));
            else
                case ($urandom_range(0, 9))
                    0:       queue_random_number(NUM_ALL_ONES);
                    1:       queue_random_number(NUM_OVERFLOW);
                    2:       queue_random_number(NUM_ZEROS);
                    3, 4, 5: queue_random_number(NUM_SHORT);
                    6, 7:    queue_random_number(NUM_LONG);
                    default: queue_random_number(NUM_LEAD_ZERO);
                endcase
            n++;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_beats.size() != 0 || have_beat || start)
            @(negedge i_clk);
        while (digits_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
